@@ rtl/thal_pkg.sv @@
package thal_pkg;

   // operation selector carried on req_tuser
   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_LSL  = 3'd2,
      CMD_LSR  = 3'd3,
      CMD_ASR  = 3'd4,
      CMD_MOV  = 3'd5,
      CMD_CMP  = 3'd6,
      CMD_COND = 3'd7
   } cmd_type;

   // ARM condition field encoding (code fifteen names no condition)
   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_CS = 4'd2,
      COND_CC = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14
   } cond_code_type;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned SHAMT_W = 5;

   // stored condition flags
   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   // one input beat after unpacking
   typedef struct packed {
      cmd_type             cmd;
      logic [DATA_W-1:0]   operand_a;
      logic [DATA_W-1:0]   operand_b;
      cond_code_type       cond_code;
   } req_item_type;

   // execute stage output
   typedef struct packed {
      logic [DATA_W-1:0]   alu_result;
      flags_type           flags;
      logic                cond_true;
   } alu_out_type;

endpackage

@@ rtl/thal_cond.sv @@
module thal_cond import thal_pkg::*; (
   input  cond_code_type cond_code,
   input  flags_type     flags,
   output logic          cond_true
);

   // condition evaluation on the flags held before this beat
   always_comb begin
      case (cond_code)
         COND_EQ: cond_true = flags.z;
         COND_NE: cond_true = !flags.z;
         COND_CS: cond_true = flags.c;
         COND_CC: cond_true = !flags.c;
         COND_MI: cond_true = flags.n;
         COND_PL: cond_true = !flags.n;
         COND_VS: cond_true = flags.v;
         COND_VC: cond_true = !flags.v;
         COND_HI: cond_true = flags.c && !flags.z;
         COND_LS: cond_true = !flags.c || flags.z;
         COND_GE: cond_true = (flags.n == flags.v);
         COND_LT: cond_true = (flags.n != flags.v);
         COND_GT: cond_true = !flags.z && (flags.n == flags.v);
         COND_LE: cond_true = flags.z || (flags.n != flags.v);
         COND_AL: cond_true = 1'b1;
         default: cond_true = 1'b0;
      endcase
   end

endmodule

@@ rtl/thal_alu.sv @@
module thal_alu import thal_pkg::*; (
   input  req_item_type item,
   input  flags_type    flags,
   output alu_out_type  alu_out
);

   logic                is_sub;
   logic [DATA_W-1:0]   b_op;
   logic [DATA_W:0]     sum;
   logic                add_v;
   logic [SHAMT_W-1:0]  shamt;
   logic                shift_zero;
   logic [DATA_W:0]     lsl_ext;
   logic signed [DATA_W+1:0] shr_src;
   logic signed [DATA_W+1:0] shr_ext;
   logic                cond_hit;
   logic [DATA_W-1:0]   result;
   flags_type           next_flags;
   logic                res_n;
   logic                res_z;

   // shared adder, subtract as a + ~b + 1 so carry out is not-borrow
   assign is_sub = (item.cmd == CMD_SUB) || (item.cmd == CMD_CMP);
   assign b_op   = is_sub ? ~item.operand_b : item.operand_b;
   assign sum    = {1'b0, item.operand_a} + {1'b0, b_op} + {{DATA_W{1'b0}}, is_sub};
   assign add_v  = (item.operand_a[DATA_W-1] == b_op[DATA_W-1])
                   && (sum[DATA_W-1] != item.operand_a[DATA_W-1]);

   // shifter, the extra bit on each side catches the last bit shifted out
   assign shamt      = item.operand_b[SHAMT_W-1:0];
   assign shift_zero = (shamt == '0);
   assign lsl_ext    = {1'b0, item.operand_a} << shamt;
   assign shr_src    = {item.operand_a[DATA_W-1] && (item.cmd == CMD_ASR),
                        item.operand_a, 1'b0};
   assign shr_ext    = shr_src >>> shamt;

   thal_cond u_cond (
      .cond_code (item.cond_code),
      .flags     (flags),
      .cond_true (cond_hit)
   );

   // result select
   always_comb begin
      case (item.cmd)
         CMD_ADD, CMD_SUB, CMD_CMP: result = sum[DATA_W-1:0];
         CMD_LSL:                   result = lsl_ext[DATA_W-1:0];
         CMD_LSR, CMD_ASR:          result = shr_ext[DATA_W:1];
         CMD_MOV:                   result = item.operand_b;
         default:                   result = '0;
      endcase
   end

   assign res_n = result[DATA_W-1];
   assign res_z = (result == '0);

   // flag update per operation
   always_comb begin
      next_flags = flags;
      case (item.cmd)
         CMD_ADD, CMD_SUB, CMD_CMP: begin
            next_flags = '{n: res_n, z: res_z, c: sum[DATA_W], v: add_v};
         end
         CMD_LSL: begin
            next_flags.n = res_n;
            next_flags.z = res_z;
            if (!shift_zero) begin
               next_flags.c = lsl_ext[DATA_W];
            end
         end
         CMD_LSR, CMD_ASR: begin
            next_flags.n = res_n;
            next_flags.z = res_z;
            if (!shift_zero) begin
               next_flags.c = shr_ext[0];
            end
         end
         CMD_MOV: begin
            next_flags.n = res_n;
            next_flags.z = res_z;
         end
         default: begin
            next_flags = flags;
         end
      endcase
   end

   assign alu_out.alu_result = result;
   assign alu_out.flags      = next_flags;
   assign alu_out.cond_true  = (item.cmd == CMD_COND) && cond_hit;

endmodule

@@ rtl/thumb_alu_flags_condition.sv @@
// Thumb-style 32-bit ALU with a stored NZCV flag register. Each request beat
// carries an operation on req_tuser (add, sub, lsl, lsr, asr, mov, cmp or
// condition test) and its operands on req_tdata; each beat yields exactly one
// response beat with the result, the flags after the operation and a
// condition-true bit. A beat is registered on entry, executed in one pass
// through the adder or shifter, and registered on exit; one beat is accepted
// every cycle while the response side keeps up. The flag register is updated
// as each beat leaves the execute stage, so the next beat always sees the
// flags of the one before; the adder and flag select in that single stage set
// the clock rate. Flags reset to zero.
module thumb_alu_flags_condition import thal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // operand_a[31:0], operand_b[63:32], cond_code[67:64], zero
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // alu_result[31:0], flag_n[32], flag_z[33], flag_c[34],
                                    // flag_v[35], cond_true[36], zero
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   alu_out_type  out_item_ff;
   flags_type    flags_ff;
   alu_out_type  alu_out;
   logic         advance;

   // execute stage moves forward when the output register is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   thal_alu u_alu (
      .item    (in_item_ff),
      .flags   (flags_ff),
      .alu_out (alu_out)
   );

   // control and flag state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= alu_out.flags;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.cmd       <= cmd_type'(req_tuser);
         in_item_ff.operand_a <= req_tdata[31:0];
         in_item_ff.operand_b <= req_tdata[63:32];
         in_item_ff.cond_code <= cond_code_type'(req_tdata[67:64]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= alu_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_item_ff.cond_true,
                        out_item_ff.flags.v,
                        out_item_ff.flags.c,
                        out_item_ff.flags.z,
                        out_item_ff.flags.n,
                        out_item_ff.alu_result};

endmodule

@@ rtl/thal_checker.sv @@
module thal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled response beat stays and holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed under stall");

   // pipeline comes out of reset empty and ready
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // request side only stalls when both stages are full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled while response side is free");

   // a condition hit only comes from a condition test, whose result is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[36] |-> rsp_tdata[31:0] == 32'd0)
      else $error("condition hit with nonzero result");

endmodule

bind thumb_alu_flags_condition thal_checker u_thal_checker (.*);

@@ verif/thumb_alu_flags_condition_tb.sv @@
module thumb_alu_flags_condition_tb;
   import thal_pkg::*;

   localparam logic [3:0] COND_NONE = 4'd15;   // names no condition
   localparam int RANDOM_BEATS = 800;
   localparam int QUIET_TAIL   = 100;           // last beats run without idling
   localparam int DRAIN_CYCLES = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;    // operand_a[31:0], operand_b[63:32], cond_code[67:64], zero
   logic [2:0]  req_tuser;    // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;    // alu_result[31:0], flag_n[32], flag_z[33], flag_c[34],
                              // flag_v[35], cond_true[36], zero

   // one row of the directed table
   typedef struct {
      cmd_type     cmd;
      logic [31:0] a;
      logic [31:0] b;
      logic [3:0]  cc;
      bit          typed;
      alu_out_type want;
   } vector_row_type;

   vector_row_type directed_rows[$];
   alu_out_type    pending_results[$];
   flags_type      shadow_flags;
   int unsigned    mismatch_count;
   int unsigned    results_checked;
   int unsigned    beats_sent;
   int unsigned    cmd_seen[8];
   bit             ready_quiet;
   int unsigned    stall_left;

   thumb_alu_flags_condition i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // does a condition hold on the given flags
   function automatic logic cond_met(logic [3:0] code, flags_type f);
      case (code)
         COND_EQ: return f.z;
         COND_NE: return !f.z;
         COND_CS: return f.c;
         COND_CC: return !f.c;
         COND_MI: return f.n;
         COND_PL: return !f.n;
         COND_VS: return f.v;
         COND_VC: return !f.v;
         COND_HI: return f.c && !f.z;
         COND_LS: return !f.c || f.z;
         COND_GE: return f.n == f.v;
         COND_LT: return f.n != f.v;
         COND_GT: return !f.z && (f.n == f.v);
         COND_LE: return f.z || (f.n != f.v);
         COND_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // executes one operation on the shadow flags and returns the response
   task automatic execute_alu(input cmd_type cmd, input logic [31:0] a, input logic [31:0] b,
                              input logic [3:0] cc, output alu_out_type res);
      logic [32:0] wide;
      logic [31:0] r;
      flags_type   f;
      int          amt;
      f   = shadow_flags;
      r   = '0;
      amt = int'(b[4:0]);
      res.cond_true = 1'b0;
      case (cmd)
         CMD_ADD: begin
            wide = {1'b0, a} + {1'b0, b};
            r    = wide[31:0];
            f.c  = wide[32];
            f.v  = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
         end
         CMD_SUB, CMD_CMP: begin
            r   = a - b;
            f.c = a >= b;
            f.v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
         end
         CMD_LSL: begin
            r = a << amt;
            if (amt != 0) f.c = a[32 - amt];
         end
         CMD_LSR, CMD_ASR: begin
            r = (cmd == CMD_ASR) ? 32'($signed(a) >>> amt) : a >> amt;
            if (amt != 0) f.c = a[amt - 1];
         end
         CMD_MOV: r = b;
         default: res.cond_true = cond_met(cc, shadow_flags);
      endcase
      // every command but the condition test rewrites n and z
      if (cmd != CMD_COND) begin
         f.n = r[31];
         f.z = (r == '0);
      end
      shadow_flags   = f;
      res.alu_result = r;
      res.flags      = f;
   endtask

   // drives one beat and waits for it to be taken, then queues its response
   task automatic send_beat(input cmd_type cmd, input logic [31:0] a, input logic [31:0] b,
                            input logic [3:0] cc, input bit typed, input alu_out_type want);
      alu_out_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, cc, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      execute_alu(cmd, a, b, cc, predicted);
      pending_results.push_back(typed ? want : predicted);
      beats_sent++;
      cmd_seen[cmd]++;
   endtask

   // lowers valid for an idle burst of random length
   task automatic idle_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clock);
   endtask

   task automatic add_row(input cmd_type cmd, input logic [31:0] a, input logic [31:0] b,
                          input logic [3:0] cc, input bit typed, input logic [36:0] want);
      vector_row_type row;
      row.cmd   = cmd;
      row.a     = a;
      row.b     = b;
      row.cc    = cc;
      row.typed = typed;
      row.want  = alu_out_type'(want);
      directed_rows.push_back(row);
   endtask

   // operand values biased toward the corners
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'($urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // response side stalls in random bursts
   always @(posedge clock) begin
      if (reset || ready_quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      alu_out_type want;
      alu_out_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.alu_result = rsp_tdata[31:0];
         got.flags.n    = rsp_tdata[32];
         got.flags.z    = rsp_tdata[33];
         got.flags.c    = rsp_tdata[34];
         got.flags.v    = rsp_tdata[35];
         got.cond_true  = rsp_tdata[36];
         if (pending_results.size() == 0) begin
            $error("response beat with nothing expected: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.alu_result !== want.alu_result) begin
               $error("alu_result expected %h got %h", want.alu_result, got.alu_result);
               mismatch_count++;
            end
            if (got.flags.n !== want.flags.n) begin
               $error("flag_n expected %b got %b", want.flags.n, got.flags.n);
               mismatch_count++;
            end
            if (got.flags.z !== want.flags.z) begin
               $error("flag_z expected %b got %b", want.flags.z, got.flags.z);
               mismatch_count++;
            end
            if (got.flags.c !== want.flags.c) begin
               $error("flag_c expected %b got %b", want.flags.c, got.flags.c);
               mismatch_count++;
            end
            if (got.flags.v !== want.flags.v) begin
               $error("flag_v expected %b got %b", want.flags.v, got.flags.v);
               mismatch_count++;
            end
            if (got.cond_true !== want.cond_true) begin
               $error("cond_true expected %b got %b", want.cond_true, got.cond_true);
               mismatch_count++;
            end
         end
      end
   end

   // main stimulus
   initial begin
      cmd_type     cmd;
      logic [31:0] a;
      logic [31:0] b;
      alu_out_type none;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= CMD_ADD;
      ready_quiet  <= 1'b0;
      shadow_flags = '0;
      none         = '0;

      // flags after reset, carries and overflows, all shifts, wraps and a selection of conditions
      add_row(CMD_COND, 32'h0, 32'h0, COND_EQ, 1, {32'h0000_0000, 4'b0000, 1'b0});
      add_row(CMD_COND, 32'h0, 32'h0, COND_AL, 1, {32'h0000_0000, 4'b0000, 1'b1});
      add_row(CMD_COND, 32'h0, 32'h0, COND_NONE, 1, {32'h0000_0000, 4'b0000, 1'b0});
      add_row(CMD_ADD, 32'hFFFF_FFFF, 32'h1, COND_EQ, 1, {32'h0000_0000, 4'b0110, 1'b0});
      add_row(CMD_ADD, 32'h7FFF_FFFF, 32'h1, COND_EQ, 1, {32'h8000_0000, 4'b1001, 1'b0});
      add_row(CMD_COND, 32'h0, 32'h0, COND_VS, 1, {32'h0000_0000, 4'b1001, 1'b1});
      add_row(CMD_SUB, 32'h0, 32'h1, COND_EQ, 1, {32'hFFFF_FFFF, 4'b1000, 1'b0});
      add_row(CMD_SUB, 32'h8000_0000, 32'h1, COND_EQ, 1, {32'h7FFF_FFFF, 4'b0011, 1'b0});
      add_row(CMD_CMP, 32'h5, 32'h5, COND_EQ, 1, {32'h0000_0000, 4'b0110, 1'b0});
      add_row(CMD_COND, 32'h0, 32'h0, COND_HI, 0, '0);
      add_row(CMD_COND, 32'h0, 32'h0, COND_LS, 0, '0);
      add_row(CMD_LSL, 32'h8000_0001, 32'h1, COND_EQ, 0, '0);
      add_row(CMD_LSL, 32'hDEAD_BEEF, 32'h20, COND_EQ, 0, '0);
      add_row(CMD_LSR, 32'h1, 32'h1, COND_EQ, 0, '0);
      add_row(CMD_LSR, 32'hFFFF_FFFF, 32'h1F, COND_EQ, 0, '0);
      add_row(CMD_ASR, 32'h8000_0000, 32'h1F, COND_EQ, 0, '0);
      add_row(CMD_ASR, 32'h4000_0000, 32'hFFFF_FFE4, COND_EQ, 0, '0);
      add_row(CMD_ASR, 32'h8000_0000, 32'h0, COND_EQ, 0, '0);
      add_row(CMD_MOV, 32'h0, 32'h0, COND_EQ, 0, '0);
      add_row(CMD_MOV, 32'hFFFF_FFFF, 32'h8000_0000, COND_EQ, 0, '0);
      add_row(CMD_COND, 32'h0, 32'h0, COND_GE, 0, '0);
      add_row(CMD_COND, 32'h0, 32'h0, COND_LT, 0, '0);
      add_row(CMD_COND, 32'h0, 32'h0, COND_GT, 0, '0);
      add_row(CMD_COND, 32'h0, 32'h0, COND_LE, 0, '0);
      add_row(CMD_COND, 32'h0, 32'h0, COND_MI, 0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].cc, directed_rows[i].typed, directed_rows[i].want);
         if ($urandom_range(0, 3) == 0) idle_gap();
      end

      // random operations with corner-biased operands
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         cmd = cmd_type'($urandom_range(0, 7));
         a   = pick_word();
         b   = pick_word();
         if ((cmd == CMD_LSL || cmd == CMD_LSR || cmd == CMD_ASR) && $urandom_range(0, 1))
            b = 32'($urandom_range(0, 31));
         if (i == RANDOM_BEATS / 3) begin
            // hold off until the pipeline is empty
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (i == RANDOM_BEATS - QUIET_TAIL) ready_quiet <= 1'b1;
         send_beat(cmd, a, b, 4'($urandom_range(0, 15)), 0, none);
         if (i < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 5) == 0) idle_gap();
      end
      req_tvalid <= 1'b0;

      // drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d beats (%0d from the directed table), checked %0d responses",
               beats_sent, directed_rows.size(), results_checked);
      $display("per command add %0d sub %0d lsl %0d lsr %0d asr %0d mov %0d cmp %0d cond %0d",
               cmd_seen[CMD_ADD], cmd_seen[CMD_SUB], cmd_seen[CMD_LSL], cmd_seen[CMD_LSR],
               cmd_seen[CMD_ASR], cmd_seen[CMD_MOV], cmd_seen[CMD_CMP], cmd_seen[CMD_COND]);
      if (mismatch_count == 0) begin
         $display("thumb_alu_flags_condition test passed");
      end else begin
         $display("thumb_alu_flags_condition test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("thumb_alu_flags_condition test failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/thal_pkg.sv
rtl/thal_cond.sv
rtl/thal_alu.sv
rtl/thumb_alu_flags_condition.sv
rtl/thal_checker.sv
verif/thumb_alu_flags_condition_tb.sv
